>>> rtl/core/vogs_pkg.sv
// Shared widths, codes and the byte decoder for the voxel occupancy grid store.
package vogs_pkg;

    // Default grid extents, handed to the top level's parameters.
    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 32;

    // Field widths.
    localparam int POS_W      = 32;
    localparam int EDGE_W     = 24;
    localparam int SIZE_XY_W  = 7;
    localparam int SIZE_Z_W   = 6;
    localparam int CODE_W     = 3;
    localparam int OCC_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [OCC_W-1:0]     t_occ;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [BYTE_W-1:0]    t_byte;

    // Decoded occupancy codes.
    localparam t_occ OCC_EMPTY     = 3'd0;
    localparam t_occ OCC_OCCUPIED  = 3'd1;
    localparam t_occ OCC_UNMAPPED  = 3'd2;
    localparam t_occ OCC_OUT       = 3'd3;
    localparam t_occ OCC_POTENTIAL = 3'd4;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_OFFSET_X = 3'd0;
    localparam t_cfg_idx CFG_OFFSET_Y = 3'd1;
    localparam t_cfg_idx CFG_OFFSET_Z = 3'd2;
    localparam t_cfg_idx CFG_EDGE     = 3'd3;
    localparam t_cfg_idx CFG_SIZE_X   = 3'd4;
    localparam t_cfg_idx CFG_SIZE_Y   = 3'd5;
    localparam t_cfg_idx CFG_SIZE_Z   = 3'd6;

    // Configuration reset values.
    localparam logic [EDGE_W-1:0]    RST_EDGE   = 24'd256;
    localparam logic [SIZE_XY_W-1:0] RST_SIZE_X = 7'd64;
    localparam logic [SIZE_XY_W-1:0] RST_SIZE_Y = 7'd64;
    localparam logic [SIZE_Z_W-1:0]  RST_SIZE_Z = 6'd32;

    // Stored byte values with a special meaning (-1, -2 and -3).
    localparam t_byte BYTE_UNMAPPED  = 8'hFF;
    localparam t_byte BYTE_OUT       = 8'hFE;
    localparam t_byte BYTE_POTENTIAL = 8'hFD;
    localparam t_byte BYTE_EMPTY     = 8'h00;

    // Positive bytes are occupied; unknown negative bytes read as unmapped.
    function automatic t_occ decode_byte(input t_byte b);
        t_occ occ;
        if (b == BYTE_EMPTY) begin
            occ = OCC_EMPTY;
        end else if (!b[BYTE_W-1]) begin
            occ = OCC_OCCUPIED;
        end else if (b == BYTE_OUT) begin
            occ = OCC_OUT;
        end else if (b == BYTE_POTENTIAL) begin
            occ = OCC_POTENTIAL;
        end else begin
            occ = OCC_UNMAPPED;
        end
        return occ;
    endfunction

endpackage

>>> rtl/core/voxel_occupancy_grid_store_unit.sv
// Top level of the voxel occupancy grid store: index divider, address math and byte store.
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ----------------------------------------
//  command   in         start high, busy low         i_command, i_pos_x/y/z, i_write_code
//  result    out        o_done strobe, one cycle     o_occupancy, o_in_bounds
//  config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// After reset the store is swept to the unmapped byte, one entry per cycle, over all
// MAX_X*MAX_Y*MAX_Z entries (131072 by default) with busy high; configuration writes go on.
// After acceptance come 32 divider steps on all three axes at once, two multiply stages
// and the store access, which raises the strobe for a write or an out-of-bounds position;
// an in-bounds read adds the S_RD state for the registered read data before the strobe.
// A new item may be taken at the edge that ends the strobe; the receiver cannot stall results.
module voxel_occupancy_grid_store_unit #(
    parameter int MAX_X = vogs_pkg::DEF_MAX_X,
    parameter int MAX_Y = vogs_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vogs_pkg::DEF_MAX_Z
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Command channel.
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_command,
    input  logic signed [vogs_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [vogs_pkg::POS_W-1:0]     i_pos_y,
    input  logic signed [vogs_pkg::POS_W-1:0]     i_pos_z,
    input  logic signed [vogs_pkg::CODE_W-1:0]    i_write_code,
    // Result channel.
    output logic                                  o_done,
    output vogs_pkg::t_occ                        o_occupancy,
    output logic                                  o_in_bounds,
    // Configuration channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  vogs_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [vogs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import vogs_pkg::*;

    // Store geometry. Index widths never drop below one bit.
    localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
    localparam int LW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int XNW   = $clog2(MAX_X + 1);
    localparam int YNW   = $clog2(MAX_Y + 1);
    localparam int ZNW   = $clog2(MAX_Z + 1);
    localparam int STW   = $clog2(POS_W);

    localparam logic [LW-1:0]  LAST_ADDR = LW'(CELLS - 1);
    localparam logic [STW-1:0] LAST_STEP = STW'(POS_W - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_MEM   = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;

    logic [2:0] r_state, n_state;

    // Configuration registers.
    logic [POS_W-1:0]     r_off [3];
    logic [EDGE_W-1:0]    r_edge;
    logic [SIZE_XY_W-1:0] r_size_x, r_size_y;
    logic [SIZE_Z_W-1:0]  r_size_z;

    // Item state.
    logic                 r_cmd;
    logic [CODE_W-1:0]    r_code;
    logic [2:0]           r_neg;
    logic [EDGE_W-1:0]    r_rem [3];
    logic [POS_W-1:0]     r_quo [3];
    logic [STW-1:0]       r_step;
    logic                 r_ok;
    logic [LW-1:0]        r_t1;
    logic [LW-1:0]        r_lin;
    logic [LW-1:0]        r_clr_addr;

    // Byte store and its registered read data.
    t_byte                r_mem [CELLS];
    t_byte                r_rdata;

    // Result registers.
    logic                 r_done;
    t_occ                 r_occ;
    logic                 r_inb;

    logic                 w_accept;
    logic [POS_W:0]       w_diff [3];
    logic [POS_W-1:0]     w_pos [3];
    logic [EDGE_W:0]      w_trial [3];
    logic                 w_sub [3];
    logic [XNW-1:0]       w_nx;
    logic [YNW-1:0]       w_ny;
    logic [ZNW-1:0]       w_nz;
    logic                 w_fit_x, w_fit_y, w_fit_z;
    logic                 w_we;
    logic [LW-1:0]        w_waddr;
    t_byte                w_wdata;
    t_byte                w_code_byte;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_occupancy = r_occ;
    assign o_in_bounds = r_inb;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    // Sizes beyond the store's extent act as the extent itself.
    assign w_nx = (32'(r_size_x) > 32'(MAX_X)) ? XNW'(MAX_X) : XNW'(r_size_x);
    assign w_ny = (32'(r_size_y) > 32'(MAX_Y)) ? YNW'(MAX_Y) : YNW'(r_size_y);
    assign w_nz = (32'(r_size_z) > 32'(MAX_Z)) ? ZNW'(MAX_Z) : ZNW'(r_size_z);

    assign w_fit_x = r_quo[0] < POS_W'(w_nx);
    assign w_fit_y = r_quo[1] < POS_W'(w_ny);
    assign w_fit_z = r_quo[2] < POS_W'(w_nz);

    // The write code is stored as its sign-extended byte.
    assign w_code_byte = {{(BYTE_W - CODE_W){r_code[CODE_W-1]}}, r_code};

    // Offset subtraction with one guard bit; the top bit flags a position below the origin.
    // One restoring-division step per axis: a quotient bit enters from the right each cycle.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_diff[a]  = {w_pos[a][POS_W-1], w_pos[a]} - {r_off[a][POS_W-1], r_off[a]};
            w_trial[a] = {r_rem[a], r_quo[a][POS_W-1]};
            w_sub[a]   = (w_trial[a] >= {1'b0, r_edge});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MEM;
            S_MEM: begin
                n_state = (r_ok && !r_cmd) ? S_RD : S_IDLE;
            end
            S_RD:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
            r_edge   <= RST_EDGE;
            r_size_x <= RST_SIZE_X;
            r_size_y <= RST_SIZE_Y;
            r_size_z <= RST_SIZE_Z;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OFFSET_X: r_off[0] <= i_cfg_data;
                CFG_OFFSET_Y: r_off[1] <= i_cfg_data;
                CFG_OFFSET_Z: r_off[2] <= i_cfg_data;
                CFG_EDGE:     r_edge   <= i_cfg_data[EDGE_W-1:0];
                CFG_SIZE_X:   r_size_x <= i_cfg_data[SIZE_XY_W-1:0];
                CFG_SIZE_Y:   r_size_y <= i_cfg_data[SIZE_XY_W-1:0];
                CFG_SIZE_Z:   r_size_z <= i_cfg_data[SIZE_Z_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + LW'(1);
        end
    end

    // Divider and address datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == S_IDLE) begin
            r_step <= '0;
        end else if (r_state == S_DIV) begin
            r_step <= r_step + STW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_code <= i_write_code;
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= w_diff[a][POS_W];
                r_rem[a] <= '0;
                r_quo[a] <= w_diff[a][POS_W-1:0];
            end
        end else if (r_state == S_DIV) begin
            for (int a = 0; a < 3; a++) begin
                r_rem[a] <= w_sub[a] ? EDGE_W'(w_trial[a] - {1'b0, r_edge})
                                     : w_trial[a][EDGE_W-1:0];
                r_quo[a] <= {r_quo[a][POS_W-2:0], w_sub[a]};
            end
        end
        if (r_state == S_MUL1) begin
            r_ok <= !(|r_neg) && (r_edge != '0) && w_fit_x && w_fit_y && w_fit_z;
            r_t1 <= LW'(r_quo[0][XW-1:0]) * LW'(w_ny) + LW'(r_quo[1][YW-1:0]);
        end
        if (r_state == S_MUL2) begin
            r_lin <= r_t1 * LW'(w_nz) + LW'(r_quo[2][ZW-1:0]);
        end
    end

    // Byte store: one write port shared by the clearing sweep and item writes.
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_MEM) && r_ok && r_cmd);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_lin;
    assign w_wdata = (r_state == S_CLEAR) ? BYTE_UNMAPPED : w_code_byte;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_lin];
    end

    // Result strobe and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == S_MEM) && !(r_ok && !r_cmd)) || (r_state == S_RD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MEM) begin
            r_occ <= r_ok ? decode_byte(w_code_byte) : OCC_OUT;
            r_inb <= r_ok;
        end else if (r_state == S_RD) begin
            r_occ <= decode_byte(r_rdata);
            r_inb <= 1'b1;
        end
    end

endmodule

>>> rtl/core/vogs_checker.sv
// Port-level checker for the voxel occupancy grid store, bound to the top level.
module vogs_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 o_done,
    input  vogs_pkg::t_occ       o_occupancy,
    input  logic                 o_in_bounds
);
    import vogs_pkg::*;

    // A position outside the grid always reports the out-of-bounds code.
    a_out_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_in_bounds |-> o_occupancy == OCC_OUT)
        else $error("out-of-bounds result carries a wrong occupancy code");

    // Every reported code is a defined occupancy value.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_occupancy == OCC_EMPTY || o_occupancy == OCC_OCCUPIED ||
                    o_occupancy == OCC_UNMAPPED || o_occupancy == OCC_OUT ||
                    o_occupancy == OCC_POTENTIAL))
        else $error("result occupancy code out of range");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // The result is strobed only once the block is free again, and never twice in a row.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobed in two consecutive cycles");

endmodule

bind voxel_occupancy_grid_store_unit vogs_checker u_vogs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_occupancy (o_occupancy),
    .o_in_bounds (o_in_bounds)
);
